>>> design/wave_particle_rhs_defines.svh
//------------------------------------------------------------------------------
// wave_particle_rhs_defines
// assertion macros used by wpr_back
//------------------------------------------------------------------------------
`ifndef WAVE_PARTICLE_RHS_DEFINES_SVH
`define WAVE_PARTICLE_RHS_DEFINES_SVH

// same-cycle implication
`define WPR_ASSERT_IMP(lbl, ck, rn, pre, post) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (pre) |-> (post)) \
        else $error("wave_particle_rhs assertion failed");

// next-cycle implication
`define WPR_ASSERT_NXT(lbl, ck, rn, pre, post) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (pre) |=> (post)) \
        else $error("wave_particle_rhs assertion failed");

`endif

>>> design/wpr_pkg.sv
//------------------------------------------------------------------------------
// wpr_pkg
// types, constants and helpers of the wave-particle right-hand side block
//------------------------------------------------------------------------------
package wpr_pkg;

    localparam int WORD_W   = 32;
    localparam int SUM_W    = 48;
    localparam int PROD_W   = 66;
    localparam int ANG_W    = 24;
    localparam int CORDIC_N = 17;
    localparam int COUNT_W  = 17;
    localparam int ADDR_W   = 3;
    localparam int Q_DEPTH  = 2;
    localparam int Q_PTR_W  = 1;
    localparam int Q_CNT_W  = 2;

    localparam logic [18:0] TWO_PI = 19'd411775;
    localparam logic signed [ANG_W-1:0] TWO_PI_A  = 24'sd411775;
    localparam logic signed [ANG_W-1:0] PI_A      = 24'sd205887;
    localparam logic signed [ANG_W-1:0] HALF_PI_A = 24'sd102943;
    localparam logic signed [ANG_W-1:0] GAIN_A    = 24'sd39797;

    localparam logic signed [WORD_W-1:0] WORD_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [WORD_W-1:0] WORD_MIN = 32'sh8000_0000;
    localparam logic signed [PROD_W-1:0] WORD_MAX_X = 66'sh7FFF_FFFF;
    localparam logic signed [PROD_W-1:0] WORD_MIN_X = -66'sh8000_0000;
    localparam logic signed [PROD_W-1:0] SUM_MAX_X = 66'sh7FFF_FFFF_FFFF;
    localparam logic signed [PROD_W-1:0] SUM_MIN_X = -66'sh8000_0000_0000;

    localparam logic REG_COUNT = 1'b0;
    localparam logic REG_ALPHA = 1'b1;

    typedef enum logic [0:0] {
        KIND_START    = 1'b0,
        KIND_PARTICLE = 1'b1
    } kind_t;

    typedef struct packed {
        kind_t                     kind;
        logic                      last;
        logic signed [WORD_W-1:0]  w0;
        logic signed [WORD_W-1:0]  w1;
        logic signed [WORD_W-1:0]  w2;
        logic signed [WORD_W-1:0]  w3;
    } item_t;

    typedef struct packed {
        logic [COUNT_W-1:0]        count;
        logic signed [WORD_W-1:0]  alpha;
    } cfg_t;

    function automatic logic signed [ANG_W-1:0] atan_lut(input logic [4:0] i);
        logic signed [ANG_W-1:0] v;
        case (i)
            5'd0:    v = 24'sd51472;
            5'd1:    v = 24'sd30386;
            5'd2:    v = 24'sd16055;
            5'd3:    v = 24'sd8150;
            5'd4:    v = 24'sd4091;
            5'd5:    v = 24'sd2047;
            5'd6:    v = 24'sd1024;
            5'd7:    v = 24'sd512;
            5'd8:    v = 24'sd256;
            5'd9:    v = 24'sd128;
            5'd10:   v = 24'sd64;
            5'd11:   v = 24'sd32;
            5'd12:   v = 24'sd16;
            5'd13:   v = 24'sd8;
            5'd14:   v = 24'sd4;
            5'd15:   v = 24'sd2;
            5'd16:   v = 24'sd1;
            default: v = 24'sd0;
        endcase
        return v;
    endfunction

    function automatic logic signed [WORD_W-1:0] sat_word(input logic signed [PROD_W-1:0] v);
        logic signed [WORD_W-1:0] r;
        if (v > WORD_MAX_X)
            r = WORD_MAX;
        else if (v < WORD_MIN_X)
            r = WORD_MIN;
        else
            r = v[WORD_W-1:0];
        return r;
    endfunction

    function automatic logic signed [SUM_W-1:0] sat_sum(input logic signed [PROD_W-1:0] v);
        logic signed [SUM_W-1:0] r;
        if (v > SUM_MAX_X)
            r = SUM_MAX_X[SUM_W-1:0];
        else if (v < SUM_MIN_X)
            r = SUM_MIN_X[SUM_W-1:0];
        else
            r = v[SUM_W-1:0];
        return r;
    endfunction

endpackage

>>> design/wpr_if.sv
//------------------------------------------------------------------------------
// wpr_if
// input and result channels with valid/ready handshake
//------------------------------------------------------------------------------
interface wpr_in_if;
    logic                valid;
    logic                ready;
    logic                action;
    logic signed [31:0]  field_amplitude;
    logic signed [31:0]  field_phase;
    logic signed [31:0]  particle_amplitude;
    logic signed [31:0]  particle_phase;
    logic signed [31:0]  particle_position;
    logic signed [31:0]  particle_detuning;
    logic                last_particle;

    modport source (
        output valid, action, field_amplitude, field_phase, particle_amplitude,
               particle_phase, particle_position, particle_detuning, last_particle,
        input  ready
    );
    modport sink (
        input  valid, action, field_amplitude, field_phase, particle_amplitude,
               particle_phase, particle_position, particle_detuning, last_particle,
        output ready
    );
endinterface

interface wpr_out_if;
    logic                valid;
    logic                ready;
    logic signed [31:0]  d_amplitude;
    logic signed [31:0]  d_phase;
    logic signed [31:0]  d_field_amplitude;
    logic signed [31:0]  d_field_phase;
    logic                sums_valid;
    logic                divide_fault;

    modport source (
        output valid, d_amplitude, d_phase, d_field_amplitude, d_field_phase,
               sums_valid, divide_fault,
        input  ready
    );
    modport sink (
        input  valid, d_amplitude, d_phase, d_field_amplitude, d_field_phase,
               sums_valid, divide_fault,
        output ready
    );
endinterface

>>> design/wpr_front.sv
//------------------------------------------------------------------------------
// wpr_front
// input beat acceptance and classification into queue items
//------------------------------------------------------------------------------
module wpr_front (
    wpr_in_if.sink          in_ch,
    input  logic            q_full,
    output logic            push,
    output wpr_pkg::item_t  item
);

    assign in_ch.ready = !q_full;
    assign push        = in_ch.valid && !q_full;

    always_comb
    begin
        if (in_ch.action)
        begin
            item.kind = wpr_pkg::KIND_PARTICLE;
            item.last = in_ch.last_particle;
            item.w0   = in_ch.particle_amplitude;
            item.w1   = in_ch.particle_phase;
            item.w2   = in_ch.particle_position;
            item.w3   = in_ch.particle_detuning;
        end
        else
        begin
            item.kind = wpr_pkg::KIND_START;
            item.last = 1'b0;
            item.w0   = in_ch.field_amplitude;
            item.w1   = in_ch.field_phase;
            item.w2   = '0;
            item.w3   = '0;
        end
    end

endmodule

>>> design/wpr_fifo.sv
//------------------------------------------------------------------------------
// wpr_fifo
// short item queue between front and back
//------------------------------------------------------------------------------
module wpr_fifo (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  wpr_pkg::item_t  push_item,
    output logic            full,
    input  logic            pop,
    output wpr_pkg::item_t  pop_item,
    output logic            empty
);

    wpr_pkg::item_t                 mem_reg [wpr_pkg::Q_DEPTH];
    logic [wpr_pkg::Q_PTR_W-1:0]    wr_ptr_reg;
    logic [wpr_pkg::Q_PTR_W-1:0]    rd_ptr_reg;
    logic [wpr_pkg::Q_CNT_W-1:0]    cnt_reg;

    assign full     = (cnt_reg == wpr_pkg::Q_CNT_W'(wpr_pkg::Q_DEPTH));
    assign empty    = (cnt_reg == '0);
    assign pop_item = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_item;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (push && !pop)
                cnt_reg <= cnt_reg + 1'b1;
            else if (pop && !push)
                cnt_reg <= cnt_reg - 1'b1;
        end
    end

endmodule

>>> design/wpr_div.sv
//------------------------------------------------------------------------------
// wpr_div
// unsigned restoring divider, one quotient bit per cycle
//------------------------------------------------------------------------------
module wpr_div (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic [63:0]  dividend,
    input  logic [32:0]  divisor,
    output logic         done,
    output logic [63:0]  quotient
);

    logic         busy_reg;
    logic         done_reg;
    logic [5:0]   cnt_reg;
    logic [32:0]  rem_reg;
    logic [63:0]  quo_reg;
    logic [32:0]  dvs_reg;
    logic [33:0]  trial;
    logic         take;

    assign done     = done_reg;
    assign quotient = quo_reg;
    assign trial    = {rem_reg, quo_reg[63]};
    assign take     = (trial >= {1'b0, dvs_reg});

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= take ? 33'(trial - {1'b0, dvs_reg}) : trial[32:0];
            quo_reg <= {quo_reg[62:0], take};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 6'd63;
            end
            else if (busy_reg)
            begin
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                    cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

endmodule

>>> design/wpr_back.sv
//------------------------------------------------------------------------------
// wpr_back
// sequencer: angle reduction, cordic, shared multiplier and divider, result
//------------------------------------------------------------------------------
`include "wave_particle_rhs_defines.svh"

module wpr_back (
    input  logic            clk,
    input  logic            rst_n,
    input  wpr_pkg::cfg_t   cfg,
    input  logic            q_empty,
    input  wpr_pkg::item_t  q_item,
    output logic            pop,
    wpr_out_if.source       out_ch
);

    typedef enum logic [9:0] {
        S_IDLE = 10'b0000000001,
        S_RED  = 10'b0000000010,
        S_FOLD = 10'b0000000100,
        S_CORD = 10'b0000001000,
        S_MUL  = 10'b0000010000,
        S_COMB = 10'b0000100000,
        S_DIV  = 10'b0001000000,
        S_DP   = 10'b0010000000,
        S_PHI  = 10'b0100000000,
        S_OUT  = 10'b1000000000
    } state_t;

    typedef enum logic [1:0] {
        DV_Q   = 2'd0,
        DV_DE  = 2'd1,
        DV_C2  = 2'd2,
        DV_PHI = 2'd3
    } div_sel_t;

    localparam logic [3:0] RED_TOP     = 4'd15;
    localparam logic [4:0] CORDIC_LAST = 5'(wpr_pkg::CORDIC_N - 1);
    localparam logic [2:0] MUL_LAST    = 3'd7;

    state_t    state_reg, state_next;
    div_sel_t  sel_reg;
    logic      go_reg, go_next;
    logic      ov_reg;
    logic      out_load;

    logic signed [31:0]  held_e_reg, held_phi_reg;
    logic signed [47:0]  sine_sum_reg, cosine_sum_reg;

    logic signed [31:0]  a_reg, delta_reg;
    logic                last_reg;
    logic                th_neg_reg;
    logic [33:0]         rem_reg;
    logic [3:0]          k_reg;
    logic signed [23:0]  r_reg, x_reg, y_reg;
    logic                neg_reg;
    logic [4:0]          i_reg;
    logic [2:0]          step_reg;
    logic signed [65:0]  prod_reg;
    logic [47:0]         sq_reg;
    logic signed [65:0]  esn_reg, ecs_reg, asn_reg, acs_reg, plo_reg, phh_reg;
    logic signed [31:0]  da_reg, t_reg, q_reg, dp_reg, de_reg, dphi_reg;
    logic signed [48:0]  c2_reg;
    logic                fault_reg;
    logic [63:0]         dvd_reg;
    logic [32:0]         dvs_reg;

    logic                div_done;
    logic [63:0]         div_quo;

    logic signed [33:0]  th_w;
    logic [33:0]         red_sub;
    logic signed [23:0]  fold_m, r0, r1, r2;
    logic                fold_neg;
    logic signed [23:0]  dx, dy, dang;
    logic signed [23:0]  sn_w, cs_w;
    logic [31:0]         abs_a, mag_alpha;
    logic signed [32:0]  ma, mb;
    logic [81:0]         tot;
    logic signed [31:0]  t_w, da_w;
    logic [63:0]         abs_ecs;
    logic                a_zero, e_zero, cnt_zero;
    logic [47:0]         abs_sine, abs_cos;
    logic [47:0]         abs_c2;
    logic [31:0]         abs_e;

    function automatic logic signed [31:0] sat_mag(input logic neg, input logic [63:0] mag);
        logic signed [31:0] r;
        if (neg)
            r = (mag > 64'h8000_0000) ? wpr_pkg::WORD_MIN : 32'(~mag + 64'd1);
        else
            r = (mag > 64'h7FFF_FFFF) ? wpr_pkg::WORD_MAX : mag[31:0];
        return r;
    endfunction

    wpr_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (go_reg),
        .dividend (dvd_reg),
        .divisor  (dvs_reg),
        .done     (div_done),
        .quotient (div_quo)
    );

    assign pop      = (state_reg == S_IDLE) && !q_empty;
    assign out_load = (state_reg == S_OUT) && (!ov_reg || out_ch.ready);
    assign a_zero   = (a_reg == 32'sd0);
    assign e_zero   = (held_e_reg == 32'sd0);
    assign cnt_zero = (cfg.count == '0);

    // angle and reduction
    assign th_w = signed'({{2{q_item.w1[31]}}, q_item.w1})
                - signed'({{2{q_item.w2[31]}}, q_item.w2})
                - signed'({{2{held_phi_reg[31]}}, held_phi_reg});
    assign red_sub = {15'd0, wpr_pkg::TWO_PI} << k_reg;

    always_comb
    begin
        fold_m = signed'({5'd0, rem_reg[18:0]});
        if (th_neg_reg)
            r0 = (fold_m != 24'sd0) ? wpr_pkg::TWO_PI_A - fold_m : 24'sd0;
        else
            r0 = fold_m;
        r1 = (r0 > wpr_pkg::PI_A) ? r0 - wpr_pkg::TWO_PI_A : r0;
        if (r1 > wpr_pkg::HALF_PI_A)
        begin
            r2       = r1 - wpr_pkg::PI_A;
            fold_neg = 1'b1;
        end
        else if (r1 < -wpr_pkg::HALF_PI_A)
        begin
            r2       = r1 + wpr_pkg::PI_A;
            fold_neg = 1'b1;
        end
        else
        begin
            r2       = r1;
            fold_neg = 1'b0;
        end
    end

    assign dx   = y_reg >>> i_reg;
    assign dy   = x_reg >>> i_reg;
    assign dang = wpr_pkg::atan_lut(i_reg);
    assign sn_w = neg_reg ? -y_reg : y_reg;
    assign cs_w = neg_reg ? -x_reg : x_reg;

    // shared multiplier operands
    assign abs_a     = a_reg[31] ? (~a_reg + 32'd1) : a_reg;
    assign mag_alpha = cfg.alpha[31] ? (~cfg.alpha + 32'd1) : cfg.alpha;

    always_comb
    begin
        case (step_reg)
            3'd0:    begin ma = {1'b0, abs_a};       mb = {1'b0, abs_a};              end
            3'd1:    begin ma = {held_e_reg[31], held_e_reg}; mb = {{9{sn_w[23]}}, sn_w}; end
            3'd2:    begin ma = {1'b0, mag_alpha};   mb = {1'b0, sq_reg[31:0]};       end
            3'd3:    begin ma = {1'b0, mag_alpha};   mb = {17'd0, sq_reg[47:32]};     end
            3'd4:    begin ma = {held_e_reg[31], held_e_reg}; mb = {{9{cs_w[23]}}, cs_w}; end
            3'd5:    begin ma = {a_reg[31], a_reg};  mb = {{9{sn_w[23]}}, sn_w};      end
            3'd6:    begin ma = {a_reg[31], a_reg};  mb = {{9{cs_w[23]}}, cs_w};      end
            default: begin ma = '0;                  mb = '0;                         end
        endcase
    end

    // alpha * a^2 term
    assign tot = {phh_reg[49:0], 32'd0} + {18'd0, plo_reg[63:0]};
    always_comb
    begin
        if (|tot[81:47])
            t_w = cfg.alpha[31] ? wpr_pkg::WORD_MIN : wpr_pkg::WORD_MAX;
        else if (cfg.alpha[31])
            t_w = -signed'({1'b0, tot[46:16]});
        else
            t_w = signed'({1'b0, tot[46:16]});
    end

    assign da_w     = wpr_pkg::sat_word(-(esn_reg >>> 17));
    assign abs_ecs  = ecs_reg[65] ? 64'(-ecs_reg) : ecs_reg[63:0];
    assign abs_sine = sine_sum_reg[47] ? (~sine_sum_reg + 48'd1) : sine_sum_reg;
    assign abs_cos  = cosine_sum_reg[47] ? (~cosine_sum_reg + 48'd1) : cosine_sum_reg;
    assign abs_c2   = c2_reg[48] ? 48'(-c2_reg) : c2_reg[47:0];
    assign abs_e    = held_e_reg[31] ? (~held_e_reg + 32'd1) : held_e_reg;

    always_comb
    begin
        state_next = state_reg;
        go_next    = 1'b0;
        unique case (state_reg)
            S_IDLE:
                if (pop && q_item.kind == wpr_pkg::KIND_PARTICLE)
                    state_next = S_RED;
            S_RED:
                if (k_reg == '0)
                    state_next = S_FOLD;
            S_FOLD:
                state_next = S_CORD;
            S_CORD:
                if (i_reg == CORDIC_LAST)
                    state_next = S_MUL;
            S_MUL:
                if (step_reg == MUL_LAST)
                    state_next = S_COMB;
            S_COMB:
            begin
                state_next = a_zero ? S_DP : S_DIV;
                go_next    = !a_zero;
            end
            S_DIV:
                if (div_done)
                begin
                    unique case (sel_reg)
                        DV_Q:    state_next = S_DP;
                        DV_DE:   go_next    = 1'b1;
                        DV_C2:   state_next = S_PHI;
                        DV_PHI:  state_next = S_OUT;
                        default: state_next = S_OUT;
                    endcase
                end
            S_DP:
            begin
                if (!last_reg)
                    state_next = S_OUT;
                else if (cnt_zero)
                    state_next = S_PHI;
                else
                begin
                    state_next = S_DIV;
                    go_next    = 1'b1;
                end
            end
            S_PHI:
            begin
                state_next = e_zero ? S_OUT : S_DIV;
                go_next    = !e_zero;
            end
            S_OUT:
                if (out_load)
                    state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            go_reg         <= 1'b0;
            ov_reg         <= 1'b0;
            held_e_reg     <= '0;
            held_phi_reg   <= '0;
            sine_sum_reg   <= '0;
            cosine_sum_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            go_reg    <= go_next;
            if (out_load)
                ov_reg <= 1'b1;
            else if (out_ch.ready)
                ov_reg <= 1'b0;
            if (pop && q_item.kind == wpr_pkg::KIND_START)
            begin
                held_e_reg     <= q_item.w0;
                held_phi_reg   <= q_item.w1;
                sine_sum_reg   <= '0;
                cosine_sum_reg <= '0;
            end
            else if (state_reg == S_COMB)
            begin
                sine_sum_reg   <= wpr_pkg::sat_sum(66'(sine_sum_reg) + (asn_reg >>> 16));
                cosine_sum_reg <= wpr_pkg::sat_sum(66'(cosine_sum_reg) + (acs_reg >>> 16));
            end
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= ma * mb;
        unique case (state_reg)
            S_IDLE:
            begin
                a_reg      <= q_item.w0;
                delta_reg  <= q_item.w3;
                last_reg   <= q_item.last;
                th_neg_reg <= th_w[33];
                rem_reg    <= th_w[33] ? 34'(-th_w) : th_w;
                k_reg      <= RED_TOP;
            end
            S_RED:
            begin
                if (rem_reg >= red_sub)
                    rem_reg <= rem_reg - red_sub;
                k_reg <= k_reg - 1'b1;
            end
            S_FOLD:
            begin
                r_reg   <= r2;
                neg_reg <= fold_neg;
                x_reg   <= wpr_pkg::GAIN_A;
                y_reg   <= '0;
                i_reg   <= '0;
            end
            S_CORD:
            begin
                if (r_reg >= 24'sd0)
                begin
                    x_reg <= x_reg - dx;
                    y_reg <= y_reg + dy;
                    r_reg <= r_reg - dang;
                end
                else
                begin
                    x_reg <= x_reg + dx;
                    y_reg <= y_reg - dy;
                    r_reg <= r_reg + dang;
                end
                i_reg    <= i_reg + 1'b1;
                step_reg <= '0;
            end
            S_MUL:
            begin
                step_reg <= step_reg + 1'b1;
                case (step_reg)
                    3'd1:    sq_reg  <= prod_reg[63:16];
                    3'd2:    esn_reg <= prod_reg;
                    3'd3:    plo_reg <= prod_reg;
                    3'd4:    phh_reg <= prod_reg;
                    3'd5:    ecs_reg <= prod_reg;
                    3'd6:    asn_reg <= prod_reg;
                    3'd7:    acs_reg <= prod_reg;
                    default: ;
                endcase
            end
            S_COMB:
            begin
                da_reg    <= da_w;
                t_reg     <= t_w;
                fault_reg <= a_zero;
                if (a_zero)
                    q_reg <= ecs_reg[65] ? wpr_pkg::WORD_MIN : wpr_pkg::WORD_MAX;
                dvd_reg <= abs_ecs;
                dvs_reg <= {abs_a, 1'b0};
                sel_reg <= DV_Q;
            end
            S_DIV:
                if (div_done)
                begin
                    unique case (sel_reg)
                        DV_Q:
                            q_reg <= sat_mag(ecs_reg[65] ^ a_reg[31], div_quo);
                        DV_DE:
                        begin
                            de_reg  <= sat_mag(sine_sum_reg[47], div_quo);
                            dvd_reg <= {16'd0, abs_cos};
                            sel_reg <= DV_C2;
                        end
                        DV_C2:
                            c2_reg <= cosine_sum_reg[47] ? -signed'(49'(div_quo))
                                                         : signed'(49'(div_quo));
                        DV_PHI:
                            dphi_reg <= sat_mag((c2_reg > 49'sd0) != held_e_reg[31], div_quo);
                        default: ;
                    endcase
                end
            S_DP:
            begin
                dp_reg <= wpr_pkg::sat_word(66'(delta_reg) - 66'(q_reg) - 66'(t_reg));
                if (!last_reg)
                begin
                    de_reg   <= '0;
                    dphi_reg <= '0;
                end
                else if (cnt_zero)
                begin
                    fault_reg <= 1'b1;
                    de_reg    <= sine_sum_reg[47] ? wpr_pkg::WORD_MIN : wpr_pkg::WORD_MAX;
                    c2_reg    <= cosine_sum_reg[47] ? 49'(wpr_pkg::WORD_MIN)
                                                    : 49'(wpr_pkg::WORD_MAX);
                end
                else
                begin
                    dvd_reg <= {16'd0, abs_sine};
                    dvs_reg <= {15'd0, cfg.count, 1'b0};
                    sel_reg <= DV_DE;
                end
            end
            S_PHI:
            begin
                if (e_zero)
                begin
                    fault_reg <= 1'b1;
                    dphi_reg  <= (c2_reg <= 49'sd0) ? wpr_pkg::WORD_MAX : wpr_pkg::WORD_MIN;
                end
                dvd_reg <= {abs_c2, 16'd0};
                dvs_reg <= {1'b0, abs_e};
                sel_reg <= DV_PHI;
            end
            S_OUT: ;
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_ch.d_amplitude       <= da_reg;
            out_ch.d_phase           <= dp_reg;
            out_ch.d_field_amplitude <= de_reg;
            out_ch.d_field_phase     <= dphi_reg;
            out_ch.sums_valid        <= last_reg;
            out_ch.divide_fault      <= fault_reg;
        end
    end

    assign out_ch.valid = ov_reg;

    `WPR_ASSERT_IMP(a_pop_idle, clk, rst_n, pop, state_reg == S_IDLE)
    `WPR_ASSERT_IMP(a_fault_cause, clk, rst_n, out_load && fault_reg, a_reg == 32'sd0 || last_reg)
    `WPR_ASSERT_IMP(a_field_zero, clk, rst_n, out_ch.valid && !out_ch.sums_valid, out_ch.d_field_amplitude == 32'sd0 && out_ch.d_field_phase == 32'sd0)
    `WPR_ASSERT_NXT(a_div_wait, clk, rst_n, state_reg == S_DIV && !div_done, state_reg == S_DIV)

endmodule

>>> design/wave_particle_rhs.sv
// a particle beat runs reduction, cordic, multiply and divide steps in that order
// throughput: one beat in the back at a time; the divider makes one quotient bit per cycle
// the queue takes two beats ahead and a finished result waits in the output register
// reset: asynchronous active-low rst_n clears held field values, sums and control
//------------------------------------------------------------------------------
// wave_particle_rhs
// wave-particle ode right-hand side with apb configuration
//------------------------------------------------------------------------------
module wave_particle_rhs (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [wpr_pkg::ADDR_W-1:0]  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    wpr_in_if.sink                      in_ch,
    wpr_out_if.source                   out_ch
);

    wpr_pkg::cfg_t   cfg_reg;
    wpr_pkg::item_t  push_item, pop_item;
    logic            push, pop, q_full, q_empty;
    logic            wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.count <= 17'd1;
            cfg_reg.alpha <= '0;
        end
        else if (wr_en)
        begin
            unique case (paddr[2])
                wpr_pkg::REG_COUNT: cfg_reg.count <= pwdata[16:0];
                wpr_pkg::REG_ALPHA: cfg_reg.alpha <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            wpr_pkg::REG_COUNT: prdata = {15'd0, cfg_reg.count};
            wpr_pkg::REG_ALPHA: prdata = cfg_reg.alpha;
            default:            prdata = '0;
        endcase
    end

    wpr_front u_front (
        .in_ch  (in_ch),
        .q_full (q_full),
        .push   (push),
        .item   (push_item)
    );

    wpr_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .full      (q_full),
        .pop       (pop),
        .pop_item  (pop_item),
        .empty     (q_empty)
    );

    wpr_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_reg),
        .q_empty (q_empty),
        .q_item  (pop_item),
        .pop     (pop),
        .out_ch  (out_ch)
    );

endmodule
